/* rtl/core/gmk_pkg.sv */
// ----------------------------------------------------------------------------
// gmk_pkg: shared types and constants of the grid maze carver
// Holds the wall word layout, the cell command, codes and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmk_pkg;

    // Largest side of the square grid, and the depths that follow from it.
    localparam int MAX_SIDE   = 8;
    localparam int WALL_DEPTH = 2 * MAX_SIDE * (MAX_SIDE - 1);
    localparam int IW         = $clog2(WALL_DEPTH + 1);
    localparam int ZW         = $clog2(MAX_SIDE * MAX_SIDE);

    // Configuration register indexes.
    localparam logic CFG_SIDE_SIZE     = 1'b0;
    localparam logic CFG_BOUNDARY_MODE = 1'b1;

    // Input opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PICK  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_MERGED    = 3'd0;
    localparam logic [2:0] ST_EMITTED   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_DONE      = 3'd3;
    localparam logic [2:0] ST_STARTED   = 3'd4;
    localparam logic [2:0] ST_NOT_READY = 3'd5;

    // One interior wall with the zone labels of the cells on either side.
    typedef struct packed {
        logic [ZW-1:0] zone_a;
        logic [ZW-1:0] zone_b;
        logic [2:0]    x;
        logic [2:0]    y;
        logic          bottom;
    } wall_t;

    // Command broadcast to every cell of the wall chain.
    typedef struct packed {
        logic          load;
        logic [IW-1:0] load_idx;
        wall_t         load_word;
        logic          shift;
        logic [IW-1:0] shift_idx;
        logic          relabel;
        logic [ZW-1:0] zone_from;
        logic [ZW-1:0] zone_to;
    } chain_cmd_t;

    // Side size as used: zero acts as one, oversize clamps to the maximum.
    function automatic logic [3:0] eff_side(input logic [3:0] side);
        logic [3:0] r;
        r = side;
        if (side == 4'd0)
        begin
            r = 4'd1;
        end
        else if (side > 4'(MAX_SIDE))
        begin
            r = 4'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/grid_maze_kruskal_carver.sv */
// Flow: one word at a time; the next word is taken once the result
// has been taken. The fill sequencer loads each cell's right wall, then
// its bottom wall.
// Reset: phase idle, list empty, boundary counters and holes cleared,
// side_size 8 and boundary_mode 0; list payload is not cleared.
// ----------------------------------------------------------------------------
// grid_maze_kruskal_carver: randomised Kruskal maze carver, top level
// Sequencer around the wall cell chain, boundary walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_kruskal_carver
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // pick_index[6:0], hole_y[9:7], hole_x[12:10]
    input  wire  [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // wall_x[2:0], wall_y[5:3], wall_bottom[6],
                                        // walls_left[13:7], carving_done[14]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  wire         cfg_we,
    input  wire         cfg_addr,
    input  wire  [3:0]  cfg_data
);
    import gmk_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_PICK  = 5'b00100,
        S_CHECK = 5'b01000,
        S_EDGE  = 5'b10000
    } state_t;

    typedef enum logic [3:0]
    {
        PH_IDLE  = 4'b0001,
        PH_CARVE = 4'b0010,
        PH_DRAIN = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    side_reg, side_next;
    logic [1:0]    mode_reg, mode_next;
    logic [IW-1:0] total_reg, total_next;
    logic [3:0]    edge_pos_reg, edge_pos_next;
    logic          edge_turn_reg, edge_turn_next;
    logic [2:0]    open_row_reg, open_row_next;
    logic [2:0]    open_col_reg, open_col_next;
    logic [3:0]    fill_side_reg, fill_side_next;
    logic [2:0]    gx_reg, gx_next, gy_reg, gy_next;
    logic          gturn_reg, gturn_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic          valid_reg, valid_next;
    logic [2:0]    ostat_reg, ostat_next;
    logic [2:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic          ob_reg, ob_next;

    chain_cmd_t    cmd;
    wall_t         pick_word, head_word;
    logic          any_sep;

    logic          in_fire;
    logic [1:0]    in_op;
    logic [6:0]    in_pick;
    logic [3:0]    s_live, fs_m1, s_m1;
    logic [ZW-1:0] cell_id;
    logic          pick_sep;

    gmk_chain u_chain
    (
        .clk            (clk),
        .cmd            (cmd),
        .wall_total     (total_reg),
        .pick_idx       (pick_reg),
        .pick_word      (pick_word),
        .head_word      (head_word),
        .any_separating (any_sep)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_pick       = s_axis_tdata[6:0];
    assign s_live        = eff_side(side_reg);
    assign s_m1          = s_live - 4'd1;
    assign fs_m1         = fill_side_reg - 4'd1;
    assign cell_id       = ZW'({3'd0, gy_reg} * {3'd0, fill_side_reg} + {6'd0, gx_reg});
    assign pick_sep      = (pick_word.zone_a != pick_word.zone_b);

    // Sequencer and chain commands.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        side_next      = side_reg;
        mode_next      = mode_reg;
        total_next     = total_reg;
        edge_pos_next  = edge_pos_reg;
        edge_turn_next = edge_turn_reg;
        open_row_next  = open_row_reg;
        open_col_next  = open_col_reg;
        fill_side_next = fill_side_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        gturn_next     = gturn_reg;
        pick_next      = pick_reg;
        valid_next     = valid_reg;
        ostat_next     = ostat_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ob_next        = ob_reg;
        cmd            = '0;
        cmd.shift_idx  = pick_reg;

        if (valid_reg && m_axis_tready)
        begin
            valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SIDE_SIZE:     side_next = cfg_data;
                CFG_BOUNDARY_MODE: mode_next = cfg_data[1:0];
                default:           side_next = side_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ostat_next = ST_NOT_READY;
                    ox_next    = 3'd0;
                    oy_next    = 3'd0;
                    ob_next    = 1'b0;
                    valid_next = 1'b1;
                    case (in_op)
                        OP_START:
                        begin
                            fill_side_next = s_live;
                            open_row_next  = s_axis_tdata[9:7];
                            open_col_next  = s_axis_tdata[12:10];
                            gx_next        = 3'd0;
                            gy_next        = 3'd0;
                            gturn_next     = 1'b0;
                            total_next     = '0;
                            edge_pos_next  = 4'd0;
                            edge_turn_next = 1'b0;
                            ostat_next     = ST_STARTED;
                            valid_next     = 1'b0;
                            state_next     = S_FILL;
                        end
                        OP_PICK:
                        begin
                            if (phase_reg == PH_CARVE)
                            begin
                                if (in_pick >= total_reg)
                                begin
                                    ostat_next = ST_RANGE;
                                end
                                else
                                begin
                                    pick_next  = in_pick;
                                    valid_next = 1'b0;
                                    state_next = S_PICK;
                                end
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (phase_reg == PH_DONE)
                            begin
                                ostat_next = ST_DONE;
                            end
                            else if (phase_reg == PH_DRAIN)
                            begin
                                valid_next = 1'b0;
                                if (total_reg != '0)
                                begin
                                    // Emit the head wall and close the gap.
                                    ostat_next    = ST_EMITTED;
                                    ox_next       = head_word.x;
                                    oy_next       = head_word.y;
                                    ob_next       = head_word.bottom;
                                    cmd.shift     = 1'b1;
                                    cmd.shift_idx = '0;
                                    total_next    = total_reg - IW'(1);
                                    state_next    = S_CHECK;
                                end
                                else
                                begin
                                    state_next = S_EDGE;
                                end
                            end
                        end
                        default:
                        begin
                            ostat_next = ST_NOT_READY;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                // Each grid step: right wall, then bottom wall.
                cmd.load_idx         = total_reg;
                cmd.load_word.zone_a = cell_id;
                cmd.load_word.x      = gx_reg;
                cmd.load_word.y      = gy_reg;
                if (!gturn_reg)
                begin
                    gturn_next = 1'b1;
                    if ({1'b0, gx_reg} != fs_m1)
                    begin
                        cmd.load             = 1'b1;
                        cmd.load_word.zone_b = cell_id + ZW'(1);
                        cmd.load_word.bottom = 1'b0;
                        total_next           = total_reg + IW'(1);
                    end
                end
                else
                begin
                    gturn_next = 1'b0;
                    if ({1'b0, gy_reg} != fs_m1)
                    begin
                        cmd.load             = 1'b1;
                        cmd.load_word.zone_b = cell_id + ZW'(fill_side_reg);
                        cmd.load_word.bottom = 1'b1;
                        total_next           = total_reg + IW'(1);
                    end
                    if ({1'b0, gx_reg} == fs_m1)
                    begin
                        gx_next = 3'd0;
                        if ({1'b0, gy_reg} == fs_m1)
                        begin
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            gy_next = gy_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        gx_next = gx_reg + 3'd1;
                    end
                end
            end

            S_PICK:
            begin
                // Remove the picked wall; merge its zones if it separated them.
                cmd.shift     = 1'b1;
                cmd.relabel   = pick_sep;
                cmd.zone_from = pick_word.zone_b;
                cmd.zone_to   = pick_word.zone_a;
                total_next    = total_reg - IW'(1);
                if (pick_sep)
                begin
                    ostat_next = ST_MERGED;
                    ox_next    = 3'd0;
                    oy_next    = 3'd0;
                    ob_next    = 1'b0;
                end
                else
                begin
                    ostat_next = ST_EMITTED;
                    ox_next    = pick_word.x;
                    oy_next    = pick_word.y;
                    ob_next    = pick_word.bottom;
                end
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                phase_next = any_sep ? PH_CARVE : PH_DRAIN;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end

            S_EDGE:
            begin
                // Each boundary position: right edge wall, then bottom edge wall.
                if (edge_pos_reg >= s_live)
                begin
                    ostat_next = ST_DONE;
                    phase_next = PH_DONE;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!edge_turn_reg)
                begin
                    edge_turn_next = 1'b1;
                    if (mode_reg[0] && (edge_pos_reg != {1'b0, open_row_reg}))
                    begin
                        ostat_next = ST_EMITTED;
                        ox_next    = s_m1[2:0];
                        oy_next    = edge_pos_reg[2:0];
                        ob_next    = 1'b0;
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    edge_turn_next = 1'b0;
                    edge_pos_next  = edge_pos_reg + 4'd1;
                    if (mode_reg[1] && (edge_pos_reg != {1'b0, open_col_reg}))
                    begin
                        ostat_next = ST_EMITTED;
                        ox_next    = edge_pos_reg[2:0];
                        oy_next    = s_m1[2:0];
                        ob_next    = 1'b1;
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            side_reg      <= 4'(MAX_SIDE);
            mode_reg      <= 2'd0;
            total_reg     <= '0;
            edge_pos_reg  <= 4'd0;
            edge_turn_reg <= 1'b0;
            open_row_reg  <= 3'd0;
            open_col_reg  <= 3'd0;
            valid_reg     <= 1'b0;
            fill_side_reg <= 4'd1;
            gx_reg        <= 3'd0;
            gy_reg        <= 3'd0;
            gturn_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            side_reg      <= side_next;
            mode_reg      <= mode_next;
            total_reg     <= total_next;
            edge_pos_reg  <= edge_pos_next;
            edge_turn_reg <= edge_turn_next;
            open_row_reg  <= open_row_next;
            open_col_reg  <= open_col_next;
            valid_reg     <= valid_next;
            fill_side_reg <= fill_side_next;
            gx_reg        <= gx_next;
            gy_reg        <= gy_next;
            gturn_reg     <= gturn_next;
        end
    end

    // Result and pick payload.
    always_ff @(posedge clk)
    begin
        pick_reg  <= pick_next;
        ostat_reg <= ostat_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ob_reg    <= ob_next;
    end

    // Output word; list count and phase hold while the result waits.
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = ostat_reg;
    assign m_axis_tdata  = {1'b0,
                            (phase_reg == PH_DRAIN) || (phase_reg == PH_DONE),
                            total_reg, ob_reg, oy_reg, ox_reg};

    // The list never outgrows the cell row.
    a_total_bound : assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= IW'(WALL_DEPTH))
        else $error("wall count beyond cell row depth");

    // Nothing new is taken while a result waits.
    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !s_axis_tready)
        else $error("input taken while result pending");

    // A finished segment has an empty list; a restart refills it first.
    a_done_empty : assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_DONE) && (state_reg == S_IDLE)) |-> (total_reg == '0))
        else $error("done phase with walls left");

    // A pick always leaves one wall fewer.
    a_pick_removes : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |=> (total_reg == $past(total_reg) - IW'(1)))
        else $error("pick did not remove a wall");

endmodule

`default_nettype wire

/* rtl/core/gmk_cell.sv */
// ----------------------------------------------------------------------------
// gmk_cell: one entry of the wall list
// Loads a new wall, or, on a removal at or below its own index, takes its
// upper neighbour's word, and relabels a merged zone in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmk_cell
(
    input  wire                      clk,
    input  wire [gmk_pkg::IW-1:0]    cell_index,
    input  gmk_pkg::chain_cmd_t      cmd,
    input  gmk_pkg::wall_t           upper_word,
    output gmk_pkg::wall_t           word,
    output logic                     separating
);
    import gmk_pkg::*;

    wall_t word_reg;
    wall_t word_next;
    wall_t base;

    // Pick the source word, then merge the zone being absorbed.
    always_comb
    begin
        base      = (cell_index >= cmd.shift_idx) ? upper_word : word_reg;
        word_next = base;
        if (cmd.relabel)
        begin
            if (base.zone_a == cmd.zone_from)
            begin
                word_next.zone_a = cmd.zone_to;
            end
            if (base.zone_b == cmd.zone_from)
            begin
                word_next.zone_b = cmd.zone_to;
            end
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (cmd.load_idx == cell_index))
        begin
            word_reg <= cmd.load_word;
        end
        else if (cmd.shift)
        begin
            word_reg <= word_next;
        end
    end

    assign word       = word_reg;
    assign separating = (word_reg.zone_a != word_reg.zone_b);

endmodule

`default_nettype wire

/* rtl/core/gmk_chain.sv */
// ----------------------------------------------------------------------------
// gmk_chain: the row of wall cells
// Each cell above a removed entry hands its word to the cell below. The
// chain also selects the picked word and reports whether any live wall
// still separates two zones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmk_chain
(
    input  wire                      clk,
    input  gmk_pkg::chain_cmd_t      cmd,
    input  wire [gmk_pkg::IW-1:0]    wall_total,
    input  wire [gmk_pkg::IW-1:0]    pick_idx,
    output gmk_pkg::wall_t           pick_word,
    output gmk_pkg::wall_t           head_word,
    output logic                     any_separating
);
    import gmk_pkg::*;

    wall_t                 words [WALL_DEPTH];
    logic [WALL_DEPTH-1:0] sep;

    // The cell row; the top cell feeds itself.
    genvar i;
    generate
        for (i = 0; i < WALL_DEPTH; i++)
        begin : g_cell
            wall_t upper;
            if (i == WALL_DEPTH - 1)
            begin : g_top
                assign upper = words[i];
            end
            else
            begin : g_mid
                assign upper = words[i + 1];
            end
            gmk_cell u_cell
            (
                .clk        (clk),
                .cell_index (IW'(i)),
                .cmd        (cmd),
                .upper_word (upper),
                .word       (words[i]),
                .separating (sep[i])
            );
        end
    endgenerate

    // Picked word, and the separating test over the live entries.
    always_comb
    begin
        pick_word      = '0;
        any_separating = 1'b0;
        for (int k = 0; k < WALL_DEPTH; k++)
        begin
            if (pick_idx == IW'(k))
            begin
                pick_word = pick_word | words[k];
            end
            if (sep[k] && (IW'(k) < wall_total))
            begin
                any_separating = 1'b1;
            end
        end
    end

    assign head_word = words[0];

endmodule

`default_nettype wire
